@@ rtl/mrpe_pkg.sv @@
// shared types, codes and frame tables for the meter register poll engine
package mrpe_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_MEAS    = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_TIMEOUT = 2'd3
  } res_kind_t;

  typedef enum logic [1:0] {
    JOB_READ   = 2'd0,
    JOB_WRITE  = 2'd1,
    JOB_SINGLE = 2'd2
  } job_kind_t;

  localparam logic [2:0] Q_PF    = 3'd0;
  localparam logic [2:0] Q_POWER = 3'd3;
  localparam logic [2:0] Q_VAR   = 3'd4;
  localparam logic [2:0] Q_TEMP  = 3'd7;

  localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
  localparam logic [7:0]  ACK_ALT     = 8'hAD;
  localparam logic [7:0]  READ_LEN    = 8'h04;
  localparam logic [7:0]  WRITE_LEN   = 8'h07;
  localparam logic [7:0]  CMD_SELECT  = 8'hA3;
  localparam logic [7:0]  CMD_READ3   = 8'hE3;
  localparam logic [7:0]  CMD_WRITE3  = 8'hD3;
  localparam logic [23:0] VAL_RESET   = 24'hBD0000;
  localparam logic [23:0] VAL_CLEAR   = 24'hEC0000;
  localparam logic [23:0] SIGN_LIMIT  = 24'h800000;
  localparam logic [7:0]  READ_BASE   = 8'(SYNC_BYTE + READ_LEN + CMD_SELECT + CMD_READ3);
  localparam logic [7:0]  WRITE_BASE  = 8'(SYNC_BYTE + WRITE_LEN + CMD_SELECT + CMD_WRITE3);

  localparam logic [15:0] POLL_RESET  = 16'd1000;
  localparam logic [9:0]  RTO_RESET   = 10'd200;
  localparam logic [9:0]  WTO_RESET   = 10'd100;

  localparam logic [3:0] LAST_READ  = 4'd6;
  localparam logic [3:0] LAST_WRITE = 4'd9;

  localparam logic [1:0] REG_POLL = 2'd0;
  localparam logic [1:0] REG_RTO  = 2'd1;
  localparam logic [1:0] REG_WTO  = 2'd2;

  typedef struct packed {
    logic [15:0] poll_interval_ms;
    logic [9:0]  read_timeout_ms;
    logic [9:0]  write_timeout_ms;
  } cfg_t;

  typedef struct packed {
    job_kind_t   jkind;
    res_kind_t   kind;
    logic [2:0]  quantity;
    logic        cmd_reset;
    logic [23:0] magnitude;
    logic        ready;
  } job_t;

  function automatic logic [15:0] reg_addr(input logic [2:0] q);
    logic [15:0] a;
    case (q)
      3'd0:    a = 16'h0048;
      3'd1:    a = 16'h0033;
      3'd2:    a = 16'h0036;
      3'd3:    a = 16'h0039;
      3'd4:    a = 16'h003C;
      3'd5:    a = 16'h0069;
      3'd6:    a = 16'h0042;
      default: a = 16'h0027;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] read_byte(input logic [3:0] idx, input logic [2:0] q);
    logic [15:0] a;
    logic [7:0]  b;
    a = reg_addr(q);
    case (idx)
      4'd0:    b = SYNC_BYTE;
      4'd1:    b = READ_LEN;
      4'd2:    b = CMD_SELECT;
      4'd3:    b = a[7:0];
      4'd4:    b = a[15:8];
      4'd5:    b = CMD_READ3;
      default: b = 8'(8'd0 - 8'(READ_BASE + a[7:0] + a[15:8]));
    endcase
    return b;
  endfunction

  function automatic logic [7:0] write_byte(input logic [3:0] idx, input logic cmd_reset);
    logic [7:0] v2;
    logic [7:0] b;
    v2 = cmd_reset ? VAL_RESET[23:16] : VAL_CLEAR[23:16];
    case (idx)
      4'd0:    b = SYNC_BYTE;
      4'd1:    b = WRITE_LEN;
      4'd2:    b = CMD_SELECT;
      4'd5:    b = CMD_WRITE3;
      4'd6:    b = cmd_reset ? VAL_RESET[7:0] : VAL_CLEAR[7:0];
      4'd7:    b = cmd_reset ? VAL_RESET[15:8] : VAL_CLEAR[15:8];
      4'd8:    b = v2;
      4'd9:    b = 8'(8'd0 - 8'(WRITE_BASE + v2));
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/meter_register_poll_engine_top.sv @@
// top level: configuration registers, poll engine core and result output stage
//
// Each input item (millisecond tick, received byte or command request) is
// taken into an input register and resolved against the poll state,
// producing at most one job: a 7-byte read frame, a 10-byte write
// frame, or a single measurement or command-status item. The output stage
// sends one result item per cycle while out_tready does not stall it; an
// input that causes no result is still resolved in its turn. While a job
// is being sent, one further input item waits in the input register and
// the input stalls; that item is resolved in the cycle the job's last
// result leaves the job register, and a new item is taken at the same
// edge. A first result passes through the input register, the job
// register and the output register before it appears on the output.
// Configuration registers sit at byte addresses 0 (poll interval), 4 (read
// timeout) and 8 (write timeout).
module meter_register_poll_engine_top import mrpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // operation
  input  logic [7:0]  in_tdata,    // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,   // kind
  output logic [39:0] out_tdata,   // tx_byte, quantity, magnitude, ready_res, zero pad
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg_r;
  logic cfg_wr;
  logic job_valid;
  logic job_ready;
  job_t job;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_interval_ms <= POLL_RESET;
      cfg_r.read_timeout_ms  <= RTO_RESET;
      cfg_r.write_timeout_ms <= WTO_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_POLL: cfg_r.poll_interval_ms <= cfg_pwdata[15:0];
        REG_RTO:  cfg_r.read_timeout_ms  <= cfg_pwdata[9:0];
        REG_WTO:  cfg_r.write_timeout_ms <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_POLL: cfg_prdata = {16'd0, cfg_r.poll_interval_ms};
      REG_RTO:  cfg_prdata = {22'd0, cfg_r.read_timeout_ms};
      REG_WTO:  cfg_prdata = {22'd0, cfg_r.write_timeout_ms};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  mrpe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  mrpe_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .job_ready  (job_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/mrpe_core.sv @@
// input register, poll and command state, and result job generation
module mrpe_core import mrpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // operation
  input  logic [7:0]  in_tdata,   // rx_byte
  input  cfg_t        cfg,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_ready
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_WRITE = 2'd2
  } phase_t;

  logic        in_valid_r;
  op_t         in_op_r;
  logic [7:0]  in_byte_r;

  logic [2:0]  poll_index_r, poll_index_nxt;
  logic [15:0] since_r, since_nxt;
  phase_t      phase_r, phase_nxt;
  logic [9:0]  wait_r, wait_nxt;
  logic [7:0]  reply_hdr_r;
  logic [23:0] reply_val_r;
  logic [2:0]  reply_count_r, reply_count_nxt;
  logic [7:0]  reply_sum_r, reply_sum_nxt;
  logic        ready_flag_r, ready_flag_nxt;
  logic        reset_pending_r, reset_pending_nxt;

  logic        fire;
  logic [15:0] since_inc;
  logic [9:0]  wait_inc;
  logic        end_read;
  logic        finish;
  res_kind_t   finish_kind;
  logic [23:0] fold_val;

  assign fire      = in_valid_r && job_ready;
  assign in_tready = !in_valid_r || job_ready;
  assign since_inc = (since_r != 16'hFFFF) ? 16'(since_r + 16'd1) : since_r;
  assign wait_inc  = 10'(wait_r + 10'd1);

  always_comb begin
    fold_val = reply_val_r;
    if ((poll_index_r inside {Q_PF, Q_POWER, Q_VAR}) && (reply_val_r >= SIGN_LIMIT)) begin
      fold_val = 24'(24'd0 - reply_val_r);
    end
  end

  always_comb begin
    poll_index_nxt    = poll_index_r;
    since_nxt         = since_r;
    phase_nxt         = phase_r;
    wait_nxt          = wait_r;
    reply_count_nxt   = reply_count_r;
    reply_sum_nxt     = reply_sum_r;
    ready_flag_nxt    = ready_flag_r;
    reset_pending_nxt = reset_pending_r;
    end_read          = 1'b0;
    finish            = 1'b0;
    finish_kind       = KIND_ACK;
    job_valid         = 1'b0;
    job.jkind         = JOB_SINGLE;
    job.kind          = KIND_TX;
    job.quantity      = 3'd0;
    job.cmd_reset     = 1'b0;
    job.magnitude     = 24'd0;

    case (in_op_r)
      OP_TICK: begin
        case (phase_r)
          PH_READ: begin
            wait_nxt = wait_inc;
            if (wait_inc >= cfg.read_timeout_ms) end_read = 1'b1;
          end
          PH_WRITE: begin
            since_nxt = since_inc;
            wait_nxt  = wait_inc;
            if (wait_inc >= cfg.write_timeout_ms) begin
              finish      = 1'b1;
              finish_kind = KIND_TIMEOUT;
            end
          end
          default: begin
            since_nxt = since_inc;
            if (since_inc >= cfg.poll_interval_ms) begin
              job_valid       = 1'b1;
              job.jkind       = JOB_READ;
              job.quantity    = poll_index_r;
              phase_nxt       = PH_READ;
              wait_nxt        = 10'd0;
              reply_count_nxt = 3'd0;
              reply_sum_nxt   = 8'd0;
            end
          end
        endcase
      end
      OP_BYTE: begin
        case (phase_r)
          PH_READ: begin
            if (reply_count_r < 3'd5) begin
              reply_sum_nxt   = 8'(reply_sum_r + in_byte_r);
              reply_count_nxt = 3'(reply_count_r + 3'd1);
            end else begin
              if (reply_hdr_r == SYNC_BYTE && 8'(8'd0 - reply_sum_r) == in_byte_r) begin
                if (poll_index_r == Q_TEMP) ready_flag_nxt = 1'b1;
                poll_index_nxt = 3'(poll_index_r + 3'd1);
                job_valid      = 1'b1;
                job.jkind      = JOB_SINGLE;
                job.kind       = KIND_MEAS;
                job.quantity   = poll_index_r;
                job.magnitude  = fold_val;
              end
              end_read = 1'b1;
            end
          end
          PH_WRITE: begin
            if (in_byte_r == SYNC_BYTE || in_byte_r == ACK_ALT) begin
              finish      = 1'b1;
              finish_kind = KIND_ACK;
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (phase_r != PH_READ && phase_r != PH_WRITE) begin
          reset_pending_nxt = (in_op_r == OP_RESET);
          job_valid         = 1'b1;
          job.jkind         = JOB_WRITE;
          job.cmd_reset     = (in_op_r == OP_RESET);
          phase_nxt         = PH_WRITE;
          wait_nxt          = 10'd0;
        end
      end
    endcase

    if (end_read) begin
      phase_nxt       = PH_IDLE;
      wait_nxt        = 10'd0;
      since_nxt       = 16'd0;
      reply_count_nxt = 3'd0;
      reply_sum_nxt   = 8'd0;
    end

    if (finish) begin
      job_valid = 1'b1;
      job.jkind = JOB_SINGLE;
      job.kind  = finish_kind;
      phase_nxt = PH_IDLE;
      wait_nxt  = 10'd0;
      if (reset_pending_r) begin
        reset_pending_nxt = 1'b0;
        poll_index_nxt    = 3'd0;
        ready_flag_nxt    = 1'b0;
        since_nxt         = 16'hFFFF;
      end
    end

    job.ready = ready_flag_nxt;
    job_valid = job_valid && fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      poll_index_r    <= 3'd0;
      since_r         <= 16'd0;
      phase_r         <= PH_IDLE;
      wait_r          <= 10'd0;
      reply_count_r   <= 3'd0;
      reply_sum_r     <= 8'd0;
      ready_flag_r    <= 1'b0;
      reset_pending_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        poll_index_r    <= poll_index_nxt;
        since_r         <= since_nxt;
        phase_r         <= phase_nxt;
        wait_r          <= wait_nxt;
        reply_count_r   <= reply_count_nxt;
        reply_sum_r     <= reply_sum_nxt;
        ready_flag_r    <= ready_flag_nxt;
        reset_pending_r <= reset_pending_nxt;
      end
    end
  end

  // input data register and reply payload bytes, kept only where later checks need them
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= op_t'(in_tuser);
      in_byte_r <= in_tdata;
    end
    if (fire && in_op_r == OP_BYTE && phase_r == PH_READ) begin
      case (reply_count_r)
        3'd0:    reply_hdr_r        <= in_byte_r;
        3'd2:    reply_val_r[7:0]   <= in_byte_r;
        3'd3:    reply_val_r[15:8]  <= in_byte_r;
        3'd4:    reply_val_r[23:16] <= in_byte_r;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/mrpe_emit.sv @@
// job register and output stage that sends frames one byte per item
module mrpe_emit import mrpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // kind
  output logic [39:0] out_tdata,  // tx_byte, quantity, magnitude, ready_res, zero pad
  output logic        out_tlast
);

  logic        job_valid_r;
  job_t        job_r;
  logic [3:0]  idx_r;
  logic [3:0]  last_idx;
  logic        emit;
  logic        done;
  logic [7:0]  tx_byte;

  logic        out_valid_r;
  res_kind_t   out_kind_r;
  logic [7:0]  out_tx_r;
  logic [2:0]  out_q_r;
  logic [23:0] out_mag_r;
  logic        out_ready_r;
  logic        out_last_r;

  always_comb begin
    case (job_r.jkind)
      JOB_READ:  last_idx = LAST_READ;
      JOB_WRITE: last_idx = LAST_WRITE;
      default:   last_idx = 4'd0;
    endcase
    case (job_r.jkind)
      JOB_READ:  tx_byte = read_byte(idx_r, job_r.quantity);
      JOB_WRITE: tx_byte = write_byte(idx_r, job_r.cmd_reset);
      default:   tx_byte = 8'h00;
    endcase
  end

  assign emit      = job_valid_r && (!out_valid_r || out_tready);
  assign done      = emit && (idx_r == last_idx);
  assign job_ready = !job_valid_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_ready) begin
        job_valid_r <= job_valid;
        idx_r       <= 4'd0;
      end else if (emit) begin
        idx_r <= 4'(idx_r + 4'd1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) job_r <= job;
    if (emit) begin
      out_last_r  <= (idx_r == last_idx);
      out_ready_r <= job_r.ready;
      if (job_r.jkind == JOB_SINGLE) begin
        out_kind_r <= job_r.kind;
        out_tx_r   <= 8'h00;
        out_q_r    <= job_r.quantity;
        out_mag_r  <= job_r.magnitude;
      end else begin
        out_kind_r <= KIND_TX;
        out_tx_r   <= tx_byte;
        out_q_r    <= 3'd0;
        out_mag_r  <= 24'd0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'b0000, out_ready_r, out_mag_r, out_q_r, out_tx_r};
  assign out_tlast  = out_last_r;

endmodule
